/* rtl/core/urlpc_pkg.sv */
package urlpc_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'd32;
  localparam logic [7:0] TEN      = 8'd10;

  typedef enum logic [1:0] {
    PH_NORMAL,
    PH_PCT,
    PH_HIGH
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_BYTE,
    CMD_ESC,
    CMD_MARK
  } cmd_kind_t;

  // One queued request: a plain byte, a byte to escape, or a bare end marker
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic        last;
  } cmd_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CH_0 + {4'd0, nib};
    end
    return CH_LA + {4'd0, nib} - TEN;
  endfunction

  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] lc;
    lc = c;
    if (c >= CH_0 && c <= CH_9) begin
      return c - CH_0;
    end
    if (c >= CH_UA && c <= CH_UZ) begin
      lc = c + CASE_OFS;
    end
    return lc - CH_LA + TEN;
  endfunction

  function automatic logic passes_unchanged(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LZ) ||
           (c >= CH_UA && c <= CH_UZ) || c == CH_DASH || c == CH_UNDER ||
           c == CH_DOT || c == CH_TILDE;
  endfunction

endpackage

/* rtl/core/urlpc_front.sv */
module urlpc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_req_valid,
  output logic              in_req_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              q_full,
  output logic              q_push,
  output urlpc_pkg::cmd_t   q_wdata
);
  import urlpc_pkg::*;

  logic       mode_r;
  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       accept;
  cmd_kind_t  kind;
  logic [7:0] data;

  assign in_req_ready = !q_full;
  assign accept       = in_req_valid && !q_full;

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    kind      = CMD_NONE;
    data      = in_byte;
    if (!mode_r) begin
      phase_nxt = PH_NORMAL;
      if (passes_unchanged(in_byte)) begin
        kind = CMD_BYTE;
      end else if (in_byte == CH_SPACE) begin
        kind = CMD_BYTE;
        data = CH_PLUS;
      end else begin
        kind = CMD_ESC;
      end
    end else begin
      unique case (phase_r)
        PH_HIGH: begin
          kind      = CMD_BYTE;
          data      = (hex_value(held_r) << 4) | hex_value(in_byte);
          phase_nxt = PH_NORMAL;
        end
        PH_PCT: begin
          if (!in_last) begin
            held_nxt  = in_byte;
            phase_nxt = PH_HIGH;
          end else if (in_byte != CH_PCT) begin
            kind = CMD_BYTE;
            data = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
          end
        end
        default: begin
          phase_nxt = PH_NORMAL;
          if (in_byte == CH_PCT) begin
            if (!in_last) begin
              phase_nxt = PH_PCT;
            end
          end else begin
            kind = CMD_BYTE;
            data = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
          end
        end
      endcase
    end
    if (in_last) begin
      phase_nxt = PH_NORMAL;
      if (kind == CMD_NONE) begin
        kind = CMD_MARK;
        data = 8'd0;
      end
    end
  end

  assign q_push       = accept && kind != CMD_NONE;
  assign q_wdata.kind = kind;
  assign q_wdata.data = data;
  assign q_wdata.last = in_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      phase_r <= PH_NORMAL;
      held_r  <= 8'd0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        held_r  <= held_nxt;
      end
    end
  end

endmodule

/* rtl/core/urlpc_queue.sv */
module urlpc_queue #(
  parameter int DEPTH = urlpc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  urlpc_pkg::cmd_t   wdata,
  output logic              full,
  input  logic              pop,
  output urlpc_pkg::cmd_t   rdata,
  output logic              empty
);
  import urlpc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] cnt_r;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = cnt_r == CNT_W'(DEPTH);
  assign empty = cnt_r == '0;
  assign rdata = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wrap_inc(wptr_r);
      end
      if (pop) begin
        rptr_r <= wrap_inc(rptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/urlpc_back.sv */
module urlpc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  urlpc_pkg::cmd_t   q_rdata,
  output logic              q_pop,
  output logic              out_req_valid,
  input  logic              out_req_ready,
  output logic [7:0]        out_byte,
  output logic              out_valid,
  output logic              out_last
);
  import urlpc_pkg::*;

  logic [1:0] step_r;
  logic       ovld_r;
  logic [7:0] obyte_r, obyte_nxt;
  logic       oval_r, oval_nxt;
  logic       olast_r, olast_nxt;
  logic       load, final_step;

  // Output stage takes a new result when empty or being drained
  assign load       = !q_empty && (!ovld_r || out_req_ready);
  assign final_step = (q_rdata.kind != CMD_ESC) || step_r == 2'd2;
  assign q_pop      = load && final_step;

  always_comb begin
    obyte_nxt = q_rdata.data;
    oval_nxt  = 1'b1;
    olast_nxt = q_rdata.last && final_step;
    unique case (q_rdata.kind)
      CMD_ESC: begin
        unique case (step_r)
          2'd0:    obyte_nxt = CH_PCT;
          2'd1:    obyte_nxt = hex_digit(q_rdata.data[7:4]);
          default: obyte_nxt = hex_digit(q_rdata.data[3:0]);
        endcase
      end
      CMD_MARK: begin
        obyte_nxt = 8'd0;
        oval_nxt  = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 2'd0;
      ovld_r <= 1'b0;
    end else begin
      if (load) begin
        step_r <= final_step ? 2'd0 : step_r + 2'd1;
        ovld_r <= 1'b1;
      end else if (out_req_ready) begin
        ovld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      obyte_r <= obyte_nxt;
      oval_r  <= oval_nxt;
      olast_r <= olast_nxt;
    end
  end

  assign out_req_valid = ovld_r;
  assign out_byte      = obyte_r;
  assign out_valid     = oval_r;
  assign out_last      = olast_r;

endmodule

/* rtl/core/url_percent_codec.sv */
// URL percent codec, form style (space <-> '+'). cfg_wdata written with
// cfg_we selects encode (0) or decode (1); write it only while the block is
// idle. A byte is taken on in_req_valid & in_req_ready and classified in the
// same cycle; a request it yields goes to a small queue (QUEUE_DEPTH
// entries), and in_req_ready drops only when that queue is full. The back
// end sends one result per cycle through a registered output stage while
// out_req_ready is high; a plain byte yields one result and an escaped
// byte in encode mode yields three ("%" and two lowercase hex digits). The
// queue lets new bytes be taken while earlier results wait for the result
// port. A request passes the queue and then the output stage on its way
// to the port. The last input byte always ends in a result with out_last
// set; out_valid is 0 on that result if it carries no byte.
module url_percent_codec #(
  parameter int QUEUE_DEPTH = urlpc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_req_valid,
  output logic       in_req_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_req_valid,
  input  logic       out_req_ready,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last
);
  import urlpc_pkg::*;

  cmd_t q_wdata, q_rdata;
  logic q_push, q_pop, q_full, q_empty;

  urlpc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_req_valid (in_req_valid),
    .in_req_ready (in_req_ready),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  urlpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  urlpc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .out_req_valid (out_req_valid),
    .out_req_ready (out_req_ready),
    .out_byte      (out_byte),
    .out_valid     (out_valid),
    .out_last      (out_last)
  );

endmodule
